>>> src/radar_image_box_merge_assert.svh
// assertion helpers for the box merge block
`ifndef RADAR_IMAGE_BOX_MERGE_ASSERT_SVH
`define RADAR_IMAGE_BOX_MERGE_ASSERT_SVH

// same-cycle implication
`define RBM_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define RBM_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> src/rbm_pkg.sv
`timescale 1ns / 1ps
package rbm_pkg;

   localparam int SIDE_BITS   = 8;
   localparam int ADDR_BITS   = 2 * SIDE_BITS;
   localparam int FRAME_DEPTH = 1 << ADDR_BITS;
   localparam int PIX_BITS    = 8;
   localparam int MSIZE_BITS  = 5;

   localparam logic [MSIZE_BITS-1:0] MSIZE_RESET = 5'd8;
   localparam logic [MSIZE_BITS-1:0] DIST_MAX    = 5'd31;
   localparam logic [ADDR_BITS-1:0]  ADDR_LAST   = 16'hFFFF;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_MERGE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [SIDE_BITS-1:0] row;
      logic [SIDE_BITS-1:0] col;
      logic [PIX_BITS-1:0]  pixel_value;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] read_value;
      logic                is_read;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [PIX_BITS-1:0]  wr_data;
   } frame_port_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HROW,
      ST_VCOL,
      ST_HSPREAD,
      ST_VSPREAD
   } seq_state_type;

endpackage

>>> src/rbm_bit_ram.sv
`timescale 1ns / 1ps
module rbm_bit_ram import rbm_pkg::*; (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic                 wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic                 rd_data
);
   logic mem [FRAME_DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/rbm_frame_ram.sv
`timescale 1ns / 1ps
module rbm_frame_ram import rbm_pkg::*; (
   input  logic                 clock,
   input  frame_port_type       port,
   output logic [PIX_BITS-1:0]  rd_data
);
   logic [PIX_BITS-1:0] mem [FRAME_DEPTH];
   logic [PIX_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      rd_data_ff <= mem[port.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/rbm_merge_seq.sv
`timescale 1ns / 1ps
module rbm_merge_seq import rbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  merge_go,
   input  logic [MSIZE_BITS-1:0] merge_size,
   input  logic [PIX_BITS-1:0]   frame_rd_data,
   output frame_port_type        frame_port,
   output logic                  busy
);
   seq_state_type state_ff, state_in;
   logic [ADDR_BITS-1:0]  cnt_ff, cnt_in;
   logic                  issued_all_ff, issued_all_in;
   logic                  s1_valid_ff;
   logic [ADDR_BITS-1:0]  s1_addr_ff;
   logic                  s1_first_ff;
   logic [MSIZE_BITS-1:0] dist_ff, dist_in;

   logic                 issue;
   logic                 pass_done;
   logic [ADDR_BITS-1:0] scan_addr;
   logic [SIDE_BITS-1:0] line;
   logic [SIDE_BITS-1:0] pos;
   logic                 s1_bit;
   logic                 hit;
   logic                 in_range;
   logic [MSIZE_BITS-1:0] dist_prev;
   logic [SIDE_BITS:0]   row_end;
   logic [SIDE_BITS:0]   col_end;

   logic                 bma_wr_en, bma_wr_data, bma_rd_data;
   logic                 bmb_wr_en, bmb_wr_data, bmb_rd_data;

   assign line = cnt_ff[ADDR_BITS-1:SIDE_BITS];
   assign pos  = cnt_ff[SIDE_BITS-1:0];
   assign pass_done = issued_all_ff && !s1_valid_ff;

   // run length since the last set bit along the current line
   assign dist_prev = s1_first_ff ? DIST_MAX : dist_ff;
   always_comb begin
      if (s1_bit) begin
         dist_in = '0;
      end else if (dist_prev == DIST_MAX) begin
         dist_in = DIST_MAX;
      end else begin
         dist_in = dist_prev + 5'd1;
      end
   end
   assign hit = dist_in < merge_size;

   // window start must leave room for the whole window
   assign row_end  = {1'b0, s1_addr_ff[ADDR_BITS-1:SIDE_BITS]} + {4'd0, merge_size};
   assign col_end  = {1'b0, s1_addr_ff[SIDE_BITS-1:0]} + {4'd0, merge_size};
   assign in_range = !row_end[SIDE_BITS] && !col_end[SIDE_BITS];

   always_comb begin
      case (state_ff)
         ST_HROW:    s1_bit = frame_rd_data != '0;
         ST_VCOL:    s1_bit = bma_rd_data;
         ST_HSPREAD: s1_bit = bmb_rd_data;
         ST_VSPREAD: s1_bit = bma_rd_data;
         default:    s1_bit = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (cnt_ff == ADDR_LAST) state_in = ST_IDLE;
         ST_IDLE:    if (merge_go) state_in = ST_HROW;
         ST_HROW:    if (pass_done) state_in = ST_VCOL;
         ST_VCOL:    if (pass_done) state_in = ST_HSPREAD;
         ST_HSPREAD: if (pass_done) state_in = ST_VSPREAD;
         ST_VSPREAD: if (pass_done) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      issue       = 1'b0;
      scan_addr   = cnt_ff;
      frame_port  = '0;
      bma_wr_en   = 1'b0;
      bma_wr_data = hit;
      bmb_wr_en   = 1'b0;
      bmb_wr_data = hit && in_range;
      case (state_ff)
         ST_CLEAR: begin
            frame_port.wr_en   = 1'b1;
            frame_port.wr_addr = cnt_ff;
         end
         ST_HROW: begin
            issue     = !issued_all_ff;
            scan_addr = {line, ~pos};
            bma_wr_en = s1_valid_ff;
         end
         ST_VCOL: begin
            issue     = !issued_all_ff;
            scan_addr = {~pos, line};
            bmb_wr_en = s1_valid_ff;
         end
         ST_HSPREAD: begin
            issue     = !issued_all_ff;
            scan_addr = {line, pos};
            bma_wr_en = s1_valid_ff;
         end
         ST_VSPREAD: begin
            issue              = !issued_all_ff;
            scan_addr          = {pos, line};
            frame_port.wr_en   = s1_valid_ff && hit;
            frame_port.wr_addr = s1_addr_ff;
            frame_port.wr_data = 8'd1;
         end
         default: begin
            issue = 1'b0;
         end
      endcase
      frame_port.rd_addr = scan_addr;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_CLEAR || issue) begin
         cnt_in = cnt_ff + 16'd1;
      end
      issued_all_in = issued_all_ff;
      if (pass_done) begin
         issued_all_in = 1'b0;
      end else if (issue && cnt_ff == ADDR_LAST) begin
         issued_all_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         issued_all_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         issued_all_ff <= issued_all_in;
         s1_valid_ff   <= issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= scan_addr;
      s1_first_ff <= pos == '0;
      if (s1_valid_ff) begin
         dist_ff <= dist_in;
      end
   end

   rbm_bit_ram u_bma (
      .clock   (clock),
      .wr_en   (bma_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (bma_wr_data),
      .rd_addr (scan_addr),
      .rd_data (bma_rd_data)
   );

   rbm_bit_ram u_bmb (
      .clock   (clock),
      .wr_en   (bmb_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (bmb_wr_data),
      .rd_addr (scan_addr),
      .rd_data (bmb_rd_data)
   );

   assign busy = state_ff != ST_IDLE;
endmodule

>>> src/radar_image_box_merge.sv
`timescale 1ns / 1ps
// Box merge over a 256 x 256 frame of byte pixels.
// Requests come in on req_data and are taken at a clock edge where start is
// high and busy is low. Opcodes: pixel write, merge over the whole frame,
// pixel read. Every request gives exactly one response on rsp_data, marked
// by rsp_valid for one cycle, in the cycle after the request is taken; only a
// read carries data in read_value, with is_read set.
// Writes and reads run at one request per cycle while busy is low, limited
// by the single frame memory port. A merge answers at once but holds busy
// high for four scans (horizontal and vertical window tests, then horizontal
// and vertical spreading), one memory access per cycle.
// The merge window side is set through the csr channel (always ready),
// reset value 8; write it only while the block is idle.
// After reset, busy stays high while the frame memory is cleared to zero. The
// response side cannot stall; a response not taken in its cycle is lost.
module radar_image_box_merge import rbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [MSIZE_BITS-1:0] csr_data
);
   logic [MSIZE_BITS-1:0] merge_size_ff;
   logic                  rsp_valid_ff;
   logic                  is_read_ff;

   logic                  accept;
   logic                  merge_go;
   frame_port_type        seq_port;
   frame_port_type        frame_port;
   logic [PIX_BITS-1:0]   frame_rd_data;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign merge_go  = accept && req_data.opcode == OP_MERGE;

   always_comb begin
      if (busy) begin
         frame_port = seq_port;
      end else begin
         frame_port.rd_addr = {req_data.row, req_data.col};
         frame_port.wr_en   = accept && req_data.opcode == OP_WRITE;
         frame_port.wr_addr = {req_data.row, req_data.col};
         frame_port.wr_data = req_data.pixel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_size_ff <= MSIZE_RESET;
         rsp_valid_ff  <= 1'b0;
         is_read_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            merge_size_ff <= csr_data;
         end
         rsp_valid_ff <= accept;
         is_read_ff   <= accept && req_data.opcode == OP_READ;
      end
   end

   rbm_merge_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .merge_go      (merge_go),
      .merge_size    (merge_size_ff),
      .frame_rd_data (frame_rd_data),
      .frame_port    (seq_port),
      .busy          (busy)
   );

   rbm_frame_ram u_frame (
      .clock   (clock),
      .port    (frame_port),
      .rd_data (frame_rd_data)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.is_read    = is_read_ff;
   assign rsp_data.read_value = is_read_ff ? frame_rd_data : '0;

`include "radar_image_box_merge_assert.svh"

   `RBM_ASSERT_NXT(a_req_gets_rsp, accept, rsp_valid)
   `RBM_ASSERT_NXT(a_no_spurious_rsp, !accept, !rsp_valid)
   `RBM_ASSERT_NXT(a_merge_holds_busy, merge_go, busy)
   `RBM_ASSERT_IMP(a_nonread_zero, rsp_valid && !rsp_data.is_read, rsp_data.read_value == '0)
endmodule
